/* design/adq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adq_pkg
// Shared types and codes of the double-ended queue with indexed read.
// ----------------------------------------------------------------------------
package adq_pkg;

  // field widths
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CNT_W  = 5;

  // capacity after reset
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

  // operation codes
  localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [FUNC_W-1:0] OP_READ       = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  // per-cell control from the sequencer
  typedef struct packed {
    logic shift_right;  // take the word of the cell toward the front
    logic shift_left;   // take the word of the cell toward the back
    logic write;        // load the pushed word
    logic read_sel;     // drive the held word onto the read bus
  } cell_ctl_t;

endpackage

/* design/adq_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adq_req_if / adq_rsp_if
// Valid/ready channels for operation requests and their results.
// ----------------------------------------------------------------------------
interface adq_req_if
  import adq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [WORD_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, func, value, position, input ready);
  modport sink   (input valid, func, value, position, output ready);
endinterface

interface adq_rsp_if
  import adq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] data;
  logic [STAT_W-1:0]        status;
  logic [CNT_W-1:0]         count;

  modport source (output valid, data, status, count, input ready);
  modport sink   (input valid, data, status, count, output ready);
endinterface

/* design/array_deque_with_index_read.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_deque_with_index_read
// Bounded double-ended queue of signed words with read at a logical index.
// ----------------------------------------------------------------------------
// Entries sit in a row of DEPTH cells in logical order, the front in cell 0.
// A push at the front shifts the whole row one cell toward the back in the
// same cycle, a pop at the front shifts it one cell toward the front, a push
// at the back loads the cell at the current count, and a pop at the back or
// an indexed read selects one cell onto an or-combined read bus. Every
// operation acts on the row as it is accepted, so one transfer is taken per
// cycle while the result register can take it; the result goes into it, and a
// new request is accepted while it is empty or being drained in the same
// cycle. The read bus across the row sets the longest path. The capacity
// register may be written only while no request is in flight.
// ----------------------------------------------------------------------------
module array_deque_with_index_read
  import adq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  adq_req_if.sink           req_i,
  adq_rsp_if.source         rsp_o
);

  // capacity register
  logic [CNT_W-1:0] cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // handshake on the request side
  logic rsp_valid_q;
  logic accept;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // decode of the accepted operation
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_d;
  logic             full;
  logic             empty;
  logic             in_range;
  logic             do_push_front;
  logic             do_push_back;
  logic             do_pop_back;
  logic             do_pop_front;
  logic             do_read;
  logic [STAT_W-1:0] status_d;

  assign full     = (int'(cnt_q) >= int'(DEPTH)) || (cnt_q >= cap_q);
  assign empty    = (cnt_q == '0);
  assign in_range = ({1'b0, req_i.position} < cnt_q);

  always_comb begin
    do_push_front = 1'b0;
    do_push_back  = 1'b0;
    do_pop_back   = 1'b0;
    do_pop_front  = 1'b0;
    do_read       = 1'b0;
    status_d      = ST_OK;
    cnt_d         = cnt_q;
    unique case (req_i.func)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          do_push_front = (req_i.func == OP_PUSH_FRONT);
          do_push_back  = (req_i.func == OP_PUSH_BACK);
          cnt_d         = cnt_q + CNT_W'(1);
        end
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          do_pop_back  = (req_i.func == OP_POP_BACK);
          do_pop_front = (req_i.func == OP_POP_FRONT);
          cnt_d        = cnt_q - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (in_range) begin
          do_read = 1'b1;
        end else begin
          status_d = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  // cell selected for a back pop or an indexed read
  logic [CNT_W-1:0] rd_idx;

  assign rd_idx = do_pop_back ? (cnt_q - CNT_W'(1)) : {1'b0, req_i.position};

  // per-cell control
  cell_ctl_t ctl [DEPTH];

  always_comb begin
    for (int i = 0; i < int'(DEPTH); i++) begin
      ctl[i].shift_right = accept && do_push_front;
      ctl[i].shift_left  = accept && do_pop_front;
      ctl[i].write       = accept && do_push_back && (int'(cnt_q) == i);
      ctl[i].read_sel    = (do_pop_back || do_read) && (int'(rd_idx) == i);
    end
  end

  // the row of cells
  logic signed [WORD_W-1:0] words    [DEPTH];
  logic signed [WORD_W-1:0] rd_words [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [WORD_W-1:0] front_word;
    logic signed [WORD_W-1:0] back_word;

    if (g == 0) begin : g_head
      assign front_word = req_i.value;
    end else begin : g_mid
      assign front_word = words[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign back_word = '0;
    end else begin : g_body
      assign back_word = words[g+1];
    end

    adq_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl[g]),
      .front_word_i (front_word),
      .back_word_i  (back_word),
      .push_word_i  (req_i.value),
      .word_o       (words[g]),
      .rd_word_o    (rd_words[g])
    );
  end

  // read bus: or of the gated cell words
  logic signed [WORD_W-1:0] rd_data;

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < int'(DEPTH); i++) begin
      rd_data = rd_data | rd_words[i];
    end
  end

  // count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  // result register
  logic signed [WORD_W-1:0] data_q;
  logic [STAT_W-1:0]        status_q;
  logic [CNT_W-1:0]         rsp_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (accept) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q    <= rd_data;
      status_q  <= status_d;
      rsp_cnt_q <= cnt_d;
    end
  end

  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.data   = data_q;
  assign rsp_o.status = status_q;
  assign rsp_o.count  = rsp_cnt_q;

  // checks
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) <= int'(DEPTH))
    else $error("entry count beyond depth");

  a_rsp_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (rsp_cnt_q == cnt_q))
    else $error("result count differs from held count");

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (status_q != ST_OK)) |-> (data_q == '0))
    else $error("failed operation returned nonzero data");

  a_empty_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && empty && ((req_i.func == OP_POP_BACK) || (req_i.func == OP_POP_FRONT)))
    |=> (rsp_valid_q && (status_q == ST_EMPTY) && (cnt_q == '0)))
    else $error("pop on empty queue not reported");

endmodule

/* design/adq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adq_cell
// One storage cell of the queue row: holds a word, shifts with its neighbors.
// ----------------------------------------------------------------------------
module adq_cell
  import adq_pkg::*;
(
  input  logic                     clk_i,
  input  cell_ctl_t                ctl_i,
  input  logic signed [WORD_W-1:0] front_word_i,
  input  logic signed [WORD_W-1:0] back_word_i,
  input  logic signed [WORD_W-1:0] push_word_i,
  output logic signed [WORD_W-1:0] word_o,
  output logic signed [WORD_W-1:0] rd_word_o
);

  logic signed [WORD_W-1:0] word_q;
  logic signed [WORD_W-1:0] word_d;

  // next word: shift either way or load a pushed word
  always_comb begin
    priority if (ctl_i.shift_right) begin
      word_d = front_word_i;
    end else if (ctl_i.shift_left) begin
      word_d = back_word_i;
    end else if (ctl_i.write) begin
      word_d = push_word_i;
    end else begin
      word_d = word_q;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o    = word_q;
  // gated so the row can be or-combined
  assign rd_word_o = ctl_i.read_sel ? word_q : '0;

endmodule

/* sim/tb_array_deque_with_index_read.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_array_deque_with_index_read
// Self-checking bench for the bounded double-ended queue with indexed read.
// ----------------------------------------------------------------------------
// A short table of directed operations covers the corner cases: empty pops,
// reads past the count, extreme words, unused operation codes, and capacities
// of one, zero and above the depth. Randomized phases follow, each with its own
// capacity and push/pop mix, so the queue swings between full and empty. Both
// handshake sides idle at random; one long response hold-off stalls requests.
// Results are checked against a ring-buffer model kept here or a pinned row.
// ----------------------------------------------------------------------------
module tb_array_deque_with_index_read
  import adq_pkg::*;
();

  localparam int unsigned RING_DEPTH    = 16;
  localparam int unsigned LONG_HOLD     = 200;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned ERR_PRINT_MAX = 20;
  localparam int unsigned N_PHASES      = 7;

  // operation codes the block treats as no-ops
  localparam logic [FUNC_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [FUNC_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [FUNC_W-1:0] OP_SPARE_C = 3'd7;

  // random phases: capacity, push share in percent, operations per phase
  localparam int unsigned PHASE_CAP  [N_PHASES] = '{16, 5, 31, 1, 0, 0, 16};
  localparam int unsigned PHASE_PUSH [N_PHASES] = '{65, 30, 60, 50, 40, 55, 45};
  localparam int unsigned PHASE_LEN  [N_PHASES] = '{300, 250, 250, 200, 150, 250, 400};
  localparam int unsigned PHASE_QUIET = 5;  // no idling on either side
  localparam int unsigned PHASE_PRESS = 2;  // long response hold-off

  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    logic [STAT_W-1:0]        status;
    logic [CNT_W-1:0]         count;
  } deque_result_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [FUNC_W-1:0]    func;
    logic [WORD_W-1:0]    value;
    logic [POS_W-1:0]     position;
    logic                 pinned;
    deque_result_t        want;
  } plan_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;

  adq_req_if req_ch ();
  adq_rsp_if rsp_ch ();

  array_deque_with_index_read #(
    .DEPTH (RING_DEPTH)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  // clock
  always #2 clk_i = ~clk_i;

  // ring-buffer model of the queue
  logic [WORD_W-1:0] ring_word [RING_DEPTH];
  logic [POS_W-1:0]  ring_head = '0;
  logic [CNT_W-1:0]  ring_held = '0;
  logic [CNT_W-1:0]  cap_limit = CAP_RESET;

  deque_result_t pending_results [$];
  deque_result_t pin_result;
  bit            pin_active  = 1'b0;
  bit            quiet_run   = 1'b0;
  bit            hold_request = 1'b0;
  bit            rsp_holding = 1'b0;

  int unsigned n_errors     = 0;
  int unsigned n_accepted   = 0;
  int unsigned n_results    = 0;
  int unsigned n_cfg_writes = 0;
  int unsigned n_cycles     = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};

  plan_row_t dir_plan [30];

  // apply one operation to the model and return the result it gives
  function automatic deque_result_t deque_step(input logic [FUNC_W-1:0] op,
                                               input logic [WORD_W-1:0] word,
                                               input logic [POS_W-1:0]  pos);
    deque_result_t    r;
    logic [CNT_W-1:0] room;
    logic [POS_W-1:0] slot;
    r    = '0;
    room = (cap_limit > CNT_W'(RING_DEPTH)) ? CNT_W'(RING_DEPTH) : cap_limit;
    case (op)
      OP_PUSH_FRONT: begin
        if (ring_held >= room) begin
          r.status = ST_FULL;
        end else begin
          ring_head            = ring_head - 1'b1;
          ring_word[ring_head] = word;
          ring_held            = ring_held + 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (ring_held >= room) begin
          r.status = ST_FULL;
        end else begin
          slot            = ring_head + ring_held[POS_W-1:0];
          ring_word[slot] = word;
          ring_held       = ring_held + 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (ring_held == '0) begin
          r.status = ST_EMPTY;
        end else begin
          ring_held = ring_held - 1'b1;
          slot      = ring_head + ring_held[POS_W-1:0];
          r.data    = ring_word[slot];
        end
      end
      OP_POP_FRONT: begin
        if (ring_held == '0) begin
          r.status = ST_EMPTY;
        end else begin
          ring_head = ring_head + 1'b1;
          ring_held = ring_held - 1'b1;
        end
      end
      OP_READ: begin
        if ({1'b0, pos} >= ring_held) begin
          r.status = ST_RANGE;
        end else begin
          slot   = ring_head + pos;
          r.data = ring_word[slot];
        end
      end
      default: ;
    endcase
    r.count = ring_held;
    return r;
  endfunction

  // directed table rows
  function automatic plan_row_t pinned_row(input logic [FUNC_W-1:0] op,
                                           input logic [WORD_W-1:0] word,
                                           input logic [POS_W-1:0]  pos,
                                           input logic [STAT_W-1:0] st,
                                           input logic [CNT_W-1:0]  cnt);
    plan_row_t row;
    row = '{1'b0, op, word, pos, 1'b1, '{'0, st, cnt}};
    return row;
  endfunction

  function automatic plan_row_t free_row(input logic [FUNC_W-1:0] op,
                                         input logic [WORD_W-1:0] word,
                                         input logic [POS_W-1:0]  pos);
    plan_row_t row;
    row = '{1'b0, op, word, pos, 1'b0, '0};
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CNT_W-1:0] cap);
    plan_row_t row;
    row = '{1'b1, OP_PUSH_FRONT, WORD_W'(cap), '0, 1'b0, '0};
    return row;
  endfunction

  // random words lean toward the extremes now and then
  function automatic logic [WORD_W-1:0] pick_word();
    logic [WORD_W-1:0] w;
    case ($urandom_range(0, 11))
      0:       w = 32'h8000_0000;
      1:       w = 32'h7fff_ffff;
      2:       w = 32'h0000_0000;
      3:       w = 32'hffff_ffff;
      default: w = $urandom();
    endcase
    return w;
  endfunction

  // request-side gap: mostly none, some short, a few long
  function automatic int unsigned send_gap();
    int unsigned roll;
    if (quiet_run || rsp_holding) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // offer one request and wait for its transfer; returns at a falling edge
  task automatic offer_op(input logic [FUNC_W-1:0] op, input logic [WORD_W-1:0] word,
                          input logic [POS_W-1:0] pos, input int unsigned gap);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.func     <= op;
    req_ch.value    <= word;
    req_ch.position <= pos;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
  endtask

  // write the capacity once nothing is in flight
  task automatic set_capacity(input logic [CNT_W-1:0] cap);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i     <= 1'b0;
    cap_limit     = cap;
    n_cfg_writes++;
  endtask

  task automatic check_field(input string what, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      n_errors++;
      if (n_errors <= ERR_PRINT_MAX)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // predict each request at its transfer
  always @(posedge clk_i) begin : predict_requests
    deque_result_t r;
    if (rst_ni && req_ch.valid && req_ch.ready) begin
      r = deque_step(req_ch.func, req_ch.value, req_ch.position);
      pending_results.push_back(pin_active ? pin_result : r);
      n_accepted++;
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin : check_results
    deque_result_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      n_results++;
      status_seen[rsp_ch.status]++;
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= ERR_PRINT_MAX)
          $display("%0t: result with none expected, expected nothing, got data %0h",
                   $time, rsp_ch.data);
      end else begin
        want = pending_results.pop_front();
        check_field("data", want.data, rsp_ch.data);
        check_field("status", WORD_W'(want.status), WORD_W'(rsp_ch.status));
        check_field("count", WORD_W'(want.count), WORD_W'(rsp_ch.count));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               n_cycles, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // response side: random stalls, plus one long hold-off on request
  initial begin : response_sink
    int unsigned idle_left;
    int unsigned held_cycles;
    int unsigned roll;
    rsp_ch.ready = 1'b0;
    idle_left    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request  = 1'b0;
        rsp_holding   = 1'b1;
        rsp_ch.ready <= 1'b0;
        held_cycles   = 0;
        while (held_cycles < LONG_HOLD) begin
          @(negedge clk_i);
          held_cycles++;
        end
        rsp_holding = 1'b0;
      end else if (idle_left != 0) begin
        rsp_ch.ready <= 1'b0;
        idle_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!quiet_run) begin
          roll = $urandom_range(0, 99);
          if (roll < 15) idle_left = $urandom_range(1, 3);
          else if (roll < 17) idle_left = $urandom_range(8, 30);
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int unsigned       n_items;
    int unsigned       roll;
    int unsigned       push_pct;
    logic [FUNC_W-1:0] op;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  cap;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    req_ch.valid    = 1'b0;
    req_ch.func     = OP_PUSH_FRONT;
    req_ch.value    = '0;
    req_ch.position = '0;

    dir_plan = '{
      pinned_row(OP_POP_BACK,   32'h0,         4'd0,  ST_EMPTY, 5'd0),
      pinned_row(OP_POP_FRONT,  32'h0,         4'd0,  ST_EMPTY, 5'd0),
      pinned_row(OP_READ,       32'h0,         4'd0,  ST_RANGE, 5'd0),
      pinned_row(OP_READ,       32'h0,         4'd15, ST_RANGE, 5'd0),
      pinned_row(OP_PUSH_BACK,  32'h7fff_ffff, 4'd0,  ST_OK,    5'd1),
      pinned_row(OP_PUSH_FRONT, 32'h8000_0000, 4'd0,  ST_OK,    5'd2),
      pinned_row(OP_PUSH_BACK,  32'hffff_ffff, 4'd0,  ST_OK,    5'd3),
      pinned_row(OP_PUSH_FRONT, 32'h0,         4'd0,  ST_OK,    5'd4),
      free_row(OP_READ, 32'h0, 4'd0),
      free_row(OP_READ, 32'h0, 4'd1),
      free_row(OP_READ, 32'h0, 4'd3),
      pinned_row(OP_READ,       32'h0,         4'd4,  ST_RANGE, 5'd4),
      free_row(OP_POP_BACK, 32'h0, 4'd0),
      pinned_row(OP_POP_FRONT,  32'h0,         4'd0,  ST_OK,    5'd2),
      pinned_row(OP_SPARE_A,    32'h0,         4'd0,  ST_OK,    5'd2),
      pinned_row(OP_SPARE_B,    32'h5555_aaaa, 4'd7,  ST_OK,    5'd2),
      pinned_row(OP_SPARE_C,    32'hffff_ffff, 4'd15, ST_OK,    5'd2),
      free_row(OP_POP_BACK, 32'h0, 4'd0),
      pinned_row(OP_POP_FRONT,  32'h0,         4'd0,  ST_OK,    5'd0),
      pinned_row(OP_READ,       32'h0,         4'd0,  ST_RANGE, 5'd0),
      cfg_row(5'd1),
      pinned_row(OP_PUSH_FRONT, 32'h5,         4'd0,  ST_OK,    5'd1),
      pinned_row(OP_PUSH_BACK,  32'h6,         4'd0,  ST_FULL,  5'd1),
      cfg_row(5'd0),
      pinned_row(OP_PUSH_BACK,  32'h7,         4'd0,  ST_FULL,  5'd1),
      free_row(OP_POP_BACK, 32'h0, 4'd0),
      pinned_row(OP_PUSH_FRONT, 32'h8,         4'd0,  ST_FULL,  5'd0),
      cfg_row(5'd31),
      pinned_row(OP_PUSH_BACK,  32'h9,         4'd0,  ST_OK,    5'd1),
      pinned_row(OP_POP_FRONT,  32'h0,         4'd0,  ST_OK,    5'd0)
    };

    // reset
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    foreach (dir_plan[i]) begin
      if (dir_plan[i].is_cfg) begin
        set_capacity(dir_plan[i].value[CNT_W-1:0]);
      end else begin
        pin_active = dir_plan[i].pinned;
        pin_result = dir_plan[i].want;
        offer_op(dir_plan[i].func, dir_plan[i].value, dir_plan[i].position, send_gap());
      end
    end
    pin_active = 1'b0;

    // random phases
    for (int ph = 0; ph < N_PHASES; ph++) begin
      cap = (ph == PHASE_QUIET) ? CNT_W'($urandom_range(2, 15)) : CNT_W'(PHASE_CAP[ph]);
      set_capacity(cap);
      quiet_run = (ph == PHASE_QUIET);
      push_pct  = PHASE_PUSH[ph];
      n_items   = 0;
      while (n_items < PHASE_LEN[ph]) begin
        if (ph == PHASE_PRESS && n_items == 20) hold_request = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 3)
          op = FUNC_W'($urandom_range(int'(OP_SPARE_A), int'(OP_SPARE_C)));
        else if (roll < 3 + push_pct)
          op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        else if (roll < 25 + push_pct)
          op = OP_READ;
        else
          op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        // reads mostly land inside the current count
        if (ring_held != '0 && $urandom_range(0, 99) < 70)
          pos = POS_W'($urandom_range(0, int'(ring_held) - 1));
        else
          pos = POS_W'($urandom_range(0, RING_DEPTH - 1));
        offer_op(op, pick_word(), pos, send_gap());
        if (op <= OP_READ) n_items++;
      end
      quiet_run = 1'b0;
    end

    // drain and finish
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    $display("covered %0d requests and %0d results across %0d capacity writes",
             n_accepted, n_results, n_cfg_writes);
    $display("status mix: ok %0d, full %0d, empty %0d, out of range %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_RANGE]);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
